/* src/u8d_pkg.sv */
// Shared types and constants for the UTF-8 sequence decoder.
package u8d_pkg;

  localparam int unsigned NUM_LANES = 4;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_INVALID    = 2'd1;
  localparam logic [1:0] ST_INCOMPLETE = 2'd2;

  localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [20:0] SURR_LO        = 21'h00D800;
  localparam logic [20:0] SURR_HI        = 21'h00DFFF;
  localparam logic [20:0] CP_MAX         = 21'h10FFFF;
  localparam logic [20:0] MIN_LEN2       = 21'h000080;
  localparam logic [20:0] MIN_LEN3       = 21'h000800;
  localparam logic [20:0] MIN_LEN4       = 21'h010000;
  localparam logic [20:0] MAX_LEN1       = 21'h00007F;
  localparam logic [20:0] MAX_LEN2       = 21'h0007FF;
  localparam logic [20:0] MAX_LEN3       = 21'h00FFFF;

  localparam logic [2:0] LEN_BAD = 3'd0;
  localparam logic [2:0] LEN_1   = 3'd1;
  localparam logic [2:0] LEN_2   = 3'd2;
  localparam logic [2:0] LEN_3   = 3'd3;
  localparam logic [2:0] LEN_4   = 3'd4;

  typedef struct packed {
    logic [7:0] lead_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
    logic [7:0] fourth_byte;
    logic [2:0] bytes_available;
  } in_item_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  bytes_consumed;
    logic [1:0]  decode_status;
  } out_item_t;

  // What one lane learns about its byte.
  typedef struct packed {
    logic       cont;
    logic [2:0] lead_len;
    logic [6:0] lead_bits;
    logic [5:0] tail_bits;
  } lane_info_t;

endpackage

/* src/u8d_lane.sv */
// One byte lane: classifies a stream byte as lead or continuation and extracts its bits.
module u8d_lane (
  input  logic [7:0]          data_byte,
  output u8d_pkg::lane_info_t info
);

  always_comb begin
    info.cont      = (data_byte[7:6] == 2'b10);
    info.tail_bits = data_byte[5:0];
    if (data_byte[7] == 1'b0) begin
      info.lead_len  = u8d_pkg::LEN_1;
      info.lead_bits = data_byte[6:0];
    end else if (data_byte[7:5] == 3'b110) begin
      info.lead_len  = u8d_pkg::LEN_2;
      info.lead_bits = {2'b00, data_byte[4:0]};
    end else if (data_byte[7:4] == 4'b1110) begin
      info.lead_len  = u8d_pkg::LEN_3;
      info.lead_bits = {3'b000, data_byte[3:0]};
    end else if (data_byte[7:3] == 5'b11110) begin
      info.lead_len  = u8d_pkg::LEN_4;
      info.lead_bits = {4'b0000, data_byte[2:0]};
    end else begin
      info.lead_len  = u8d_pkg::LEN_BAD;
      info.lead_bits = 7'd0;
    end
  end

endmodule

/* src/u8d_merge.sv */
// Merge stage: combines the lane findings into one decoded result.
module u8d_merge (
  input  u8d_pkg::lane_info_t [3:0] lanes,
  input  logic [2:0]                avail,
  output u8d_pkg::out_item_t        result
);

  logic [2:0]  len;
  logic [20:0] value;
  logic        range_bad;

  assign len = lanes[0].lead_len;

  always_comb begin
    case (len)
      u8d_pkg::LEN_1: value = {14'd0, lanes[0].lead_bits};
      u8d_pkg::LEN_2: value = {10'd0, lanes[0].lead_bits[4:0], lanes[1].tail_bits};
      u8d_pkg::LEN_3: value = {5'd0, lanes[0].lead_bits[3:0], lanes[1].tail_bits,
                               lanes[2].tail_bits};
      default:        value = {lanes[0].lead_bits[2:0], lanes[1].tail_bits,
                               lanes[2].tail_bits, lanes[3].tail_bits};
    endcase
  end

  always_comb begin
    case (len)
      u8d_pkg::LEN_1: range_bad = (value > u8d_pkg::MAX_LEN1);
      u8d_pkg::LEN_2: range_bad = (value < u8d_pkg::MIN_LEN2) ||
                                  (value > u8d_pkg::MAX_LEN2);
      u8d_pkg::LEN_3: range_bad = (value < u8d_pkg::MIN_LEN3) ||
                                  (value > u8d_pkg::MAX_LEN3);
      default:        range_bad = (value < u8d_pkg::MIN_LEN4) ||
                                  (value > u8d_pkg::CP_MAX);
    endcase
    if (value >= u8d_pkg::SURR_LO && value <= u8d_pkg::SURR_HI) begin
      range_bad = 1'b1;
    end
  end

  always_comb begin
    result.code_point     = u8d_pkg::REPLACEMENT_CP;
    result.bytes_consumed = 3'd0;
    result.decode_status  = u8d_pkg::ST_INCOMPLETE;
    if (avail == 3'd0) begin
      result.decode_status = u8d_pkg::ST_INCOMPLETE;
    end else if (len == u8d_pkg::LEN_BAD) begin
      result.bytes_consumed = 3'd1;
      result.decode_status  = u8d_pkg::ST_INVALID;
    end else if (len > 3'd1 && avail > 3'd1 && !lanes[1].cont) begin
      // The first byte that should continue the sequence does not.
      result.bytes_consumed = 3'd1;
      result.decode_status  = u8d_pkg::ST_INVALID;
    end else if (len > 3'd2 && avail > 3'd2 && !lanes[2].cont) begin
      result.bytes_consumed = 3'd2;
      result.decode_status  = u8d_pkg::ST_INVALID;
    end else if (len > 3'd3 && avail > 3'd3 && !lanes[3].cont) begin
      result.bytes_consumed = 3'd3;
      result.decode_status  = u8d_pkg::ST_INVALID;
    end else if (avail < len) begin
      result.decode_status = u8d_pkg::ST_INCOMPLETE;
    end else if (range_bad) begin
      result.bytes_consumed = len;
      result.decode_status  = u8d_pkg::ST_INVALID;
    end else begin
      result.code_point     = value;
      result.bytes_consumed = len;
      result.decode_status  = u8d_pkg::ST_OK;
    end
  end

endmodule

/* src/utf8_sequence_decoder_core.sv */
// Top level of the UTF-8 sequence decoder: byte lanes, merge stage and output register.
//
// The decoder takes one transaction per clock while in_stall is low: up to four bytes
// from the head of a byte stream plus a count of how many are real, and returns one
// transaction with the decoded code point, the number of bytes to drop from the stream,
// and a status (ok, invalid, or incomplete, which asks for more bytes and consumes none).
// Invalid and incomplete results carry 0xFFFD. Counts above four are treated as four.
// In the block, four identical byte lanes classify their bytes into a lane register,
// and a merge stage folds the lane findings into the output register. Throughput is
// one transaction every cycle; the pipeline keeps moving as long as the output register
// is empty or being taken, and in_stall rises only when both stages hold a transaction
// and the output side is stalling. There is no configuration and no state beyond the
// two pipeline stages, so nothing needs to be cleared after reset.
module utf8_sequence_decoder_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  u8d_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output u8d_pkg::out_item_t out_data
);

  u8d_pkg::lane_info_t [3:0] lane_info;
  logic [2:0]                avail_clamped;

  // Lane stage registers.
  logic                      s1_valid_r;
  logic                      s1_valid_nxt;
  u8d_pkg::lane_info_t [3:0] s1_lanes_r;
  logic [2:0]                s1_avail_r;

  // Output register.
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  u8d_pkg::out_item_t        out_data_r;
  u8d_pkg::out_item_t        merged;

  logic                      s2_free;
  logic                      s1_adv;
  logic                      in_accept;

  u8d_lane u_lane0 (.data_byte(in_data.lead_byte),   .info(lane_info[0]));
  u8d_lane u_lane1 (.data_byte(in_data.second_byte), .info(lane_info[1]));
  u8d_lane u_lane2 (.data_byte(in_data.third_byte),  .info(lane_info[2]));
  u8d_lane u_lane3 (.data_byte(in_data.fourth_byte), .info(lane_info[3]));

  // Counts of five to seven mean the same as four.
  assign avail_clamped = (in_data.bytes_available > 3'd4) ? 3'd4 : in_data.bytes_available;

  u8d_merge u_merge (
    .lanes (s1_lanes_r),
    .avail (s1_avail_r),
    .result(merged)
  );

  // The output register can take a new result when it is empty or being drained.
  assign s2_free   = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && s2_free;
  assign in_stall  = s1_valid_r && !s2_free;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_lanes_r <= lane_info;
      s1_avail_r <= avail_clamped;
    end
    if (s1_adv) begin
      out_data_r <= merged;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* src/u8d_checker.sv */
// Port-level assertion checker for the UTF-8 sequence decoder, with its bind.
module u8d_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input u8d_pkg::out_item_t out_data
);

  // A stalled result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or vanished while stalled");

  // With the output register empty the decoder must never push back.
  a_no_needless_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output side is empty");

  // A valid result is a scalar value that consumed at least one byte.
  a_ok_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.decode_status == u8d_pkg::ST_OK |->
      out_data.bytes_consumed != 3'd0 && out_data.bytes_consumed <= 3'd4 &&
      out_data.code_point <= u8d_pkg::CP_MAX &&
      (out_data.code_point < u8d_pkg::SURR_LO || out_data.code_point > u8d_pkg::SURR_HI))
    else $error("ok result with bad value or length");

  // Incomplete consumes nothing; invalid consumes something; both carry 0xFFFD.
  a_bad_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.decode_status != u8d_pkg::ST_OK |->
      out_data.code_point == u8d_pkg::REPLACEMENT_CP &&
      ((out_data.decode_status == u8d_pkg::ST_INCOMPLETE &&
        out_data.bytes_consumed == 3'd0) ||
       (out_data.decode_status == u8d_pkg::ST_INVALID &&
        out_data.bytes_consumed != 3'd0)))
    else $error("invalid or incomplete result inconsistent");

endmodule

bind utf8_sequence_decoder_core u8d_checker u_u8d_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
